// ===== hw/rtl/grcf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grcf_pkg
// Shared types and constants of the gated recurrent cell forward core.
// ----------------------------------------------------------------------------
package grcf_pkg;

  // Item kinds carried in the input tuser field.
  localparam logic [2:0] ACTION_W_IN   = 3'd0;
  localparam logic [2:0] ACTION_W_REC  = 3'd1;
  localparam logic [2:0] ACTION_W_GATE = 3'd2;
  localparam logic [2:0] ACTION_BIAS   = 3'd3;
  localparam logic [2:0] ACTION_HIDDEN = 3'd4;
  localparam logic [2:0] ACTION_STEP   = 3'd5;

  // 1.0 in Q4.12 and in Q1.31.
  localparam logic signed [15:0] ONE_Q12 = 16'sd4096;
  localparam logic [31:0]        ONE_Q31 = 32'h8000_0000;

  // Exponential series length and divider length.
  localparam logic [4:0] SERIES_TERMS = 5'd24;
  localparam logic [5:0] DIV_LAST     = 6'd47;

  typedef enum logic {
    ACT_TANH    = 1'b0,
    ACT_SIGMOID = 1'b1
  } act_fn_t;

  typedef struct packed {
    logic             start;
    act_fn_t          fn;
    logic [15:0]      arg;
  } act_req_t;

  typedef struct packed {
    logic             done;
    logic [15:0]      result;
  } act_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/grcf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grcf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module grcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/grcf_act.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grcf_act
// Iterative tanh / sigmoid unit: exp(-t) by a truncated power series on one
// shared 32x32 multiplier and a bit-serial divider, then one long division.
// ----------------------------------------------------------------------------
module grcf_act
  import grcf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  act_req_t req,
  output act_rsp_t rsp
);

  typedef enum logic [7:0] {
    A_IDLE = 8'b0000_0001,
    A_MUL  = 8'b0000_0010,
    A_DIV  = 8'b0000_0100,
    A_TERM = 8'b0000_1000,
    A_SUM  = 8'b0001_0000,
    A_POW  = 8'b0010_0000,
    A_FIN  = 8'b0100_0000,
    A_DONE = 8'b1000_0000
  } act_state_t;

  act_state_t state_r, state_nxt;

  act_fn_t            fn_r, fn_nxt;
  logic               neg_r, neg_nxt;
  logic [4:0]         q_r, q_nxt;
  logic [11:0]        frac_r, frac_nxt;
  logic               pass_r, pass_nxt;
  logic               fin_r, fin_nxt;
  logic [31:0]        t_r, t_nxt;
  logic [31:0]        term_r, term_nxt;
  logic signed [34:0] sum_r, sum_nxt;
  logic [4:0]         n_r, n_nxt;
  logic [31:0]        e1_r, e1_nxt;
  logic [31:0]        res_r, res_nxt;
  logic [47:0]        dvd_r, dvd_nxt;
  logic [33:0]        dvs_r, dvs_nxt;
  logic [33:0]        rem_r, rem_nxt;
  logic [47:0]        quo_r, quo_nxt;
  logic [5:0]         cnt_r, cnt_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [34:0] rem_sh;
  logic [16:0] arg_ext, mag, kval;
  logic [31:0] e_clamp;
  logic [32:0] den;
  logic [31:0] num;
  logic [15:0] rq;

  assign mul_a = (state_r == A_POW) ? res_r : term_r;
  assign mul_b = (state_r == A_POW) ? e1_r  : t_r;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign rem_sh = {rem_r, dvd_r[47]};

  assign arg_ext = {req.arg[15], req.arg};
  assign mag     = arg_ext[16] ? (~arg_ext + 17'd1) : arg_ext;
  assign kval    = (req.fn == ACT_TANH) ? {mag[15:0], 1'b0} : mag;

  // Clamp the series sum to [0, 1.0].
  always_comb begin
    if (sum_r[34]) begin
      e_clamp = '0;
    end else if (sum_r > 35'(ONE_Q31)) begin
      e_clamp = ONE_Q31;
    end else begin
      e_clamp = sum_r[31:0];
    end
  end

  assign den = 33'(ONE_Q31) + 33'(res_r);
  assign num = ONE_Q31 - res_r;
  assign rq  = {3'b000, quo_r[12:0]};

  always_comb begin
    state_nxt = state_r;
    fn_nxt    = fn_r;
    neg_nxt   = neg_r;
    q_nxt     = q_r;
    frac_nxt  = frac_r;
    pass_nxt  = pass_r;
    fin_nxt   = fin_r;
    t_nxt     = t_r;
    term_nxt  = term_r;
    sum_nxt   = sum_r;
    n_nxt     = n_r;
    e1_nxt    = e1_r;
    res_nxt   = res_r;
    dvd_nxt   = dvd_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    rsp.done   = 1'b0;
    rsp.result = '0;

    unique case (state_r)
      A_IDLE: begin
        if (req.start) begin
          fn_nxt    = req.fn;
          neg_nxt   = req.arg[15];
          q_nxt     = kval[16:12];
          frac_nxt  = kval[11:0];
          pass_nxt  = 1'b0;
          t_nxt     = ONE_Q31;
          term_nxt  = ONE_Q31;
          sum_nxt   = 35'(ONE_Q31);
          n_nxt     = 5'd1;
          state_nxt = A_MUL;
        end
      end
      A_MUL: begin
        dvd_nxt   = {16'd0, mul_p[62:31]};
        dvs_nxt   = 34'(n_r);
        rem_nxt   = '0;
        quo_nxt   = '0;
        cnt_nxt   = '0;
        fin_nxt   = 1'b0;
        state_nxt = A_DIV;
      end
      A_DIV: begin
        dvd_nxt = {dvd_r[46:0], 1'b0};
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_nxt = 34'(rem_sh - {1'b0, dvs_r});
          quo_nxt = {quo_r[46:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[33:0];
          quo_nxt = {quo_r[46:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = fin_r ? A_DONE : A_TERM;
        end
      end
      A_TERM: begin
        term_nxt = quo_r[31:0];
        if (n_r[0]) begin
          sum_nxt = sum_r - 35'(quo_r[31:0]);
        end else begin
          sum_nxt = sum_r + 35'(quo_r[31:0]);
        end
        if (n_r == SERIES_TERMS) begin
          state_nxt = A_SUM;
        end else begin
          n_nxt     = n_r + 5'd1;
          state_nxt = A_MUL;
        end
      end
      A_SUM: begin
        if (!pass_r) begin
          // First pass gives exp(-1); the second gives exp of minus the fraction.
          e1_nxt    = e_clamp;
          pass_nxt  = 1'b1;
          t_nxt     = {1'b0, frac_r, 19'd0};
          term_nxt  = ONE_Q31;
          sum_nxt   = 35'(ONE_Q31);
          n_nxt     = 5'd1;
          state_nxt = A_MUL;
        end else begin
          res_nxt   = e_clamp;
          state_nxt = A_POW;
        end
      end
      A_POW: begin
        if (q_r == 5'd0) begin
          state_nxt = A_FIN;
        end else begin
          res_nxt = mul_p[62:31];
          q_nxt   = q_r - 5'd1;
        end
      end
      A_FIN: begin
        if (fn_r == ACT_TANH) begin
          dvd_nxt = 48'({num, 13'd0}) + 48'(den);
        end else begin
          dvd_nxt = 48'({ONE_Q31, 13'd0}) + 48'(den);
        end
        dvs_nxt   = {den, 1'b0};
        rem_nxt   = '0;
        quo_nxt   = '0;
        cnt_nxt   = '0;
        fin_nxt   = 1'b1;
        state_nxt = A_DIV;
      end
      A_DONE: begin
        rsp.done = 1'b1;
        if (fn_r == ACT_TANH) begin
          rsp.result = neg_r ? (16'd0 - rq) : rq;
        end else begin
          rsp.result = neg_r ? (ONE_Q12 - rq) : rq;
        end
        state_nxt = A_IDLE;
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    fn_r   <= fn_nxt;
    neg_r  <= neg_nxt;
    q_r    <= q_nxt;
    frac_r <= frac_nxt;
    pass_r <= pass_nxt;
    fin_r  <= fin_nxt;
    t_r    <= t_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
    n_r    <= n_nxt;
    e1_r   <= e1_nxt;
    res_r  <= res_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gated_recurrent_cell_forward_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gated_recurrent_cell_forward_core
// One forward step of a recurrent cell with a sigmoid output gate.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | tdata (low bit up)              | tuser            | tlast
//   --------+-----------+---------------------------------+------------------+---------
//   in_     | slave     | row, col, value, z_value        | action, sequence | last
//   out_    | master    | index, hidden_out, gated_out, 0 | out_sequence     | last_out
//
// Load items (weights, bias, initial hidden) and step elements without the
// last flag complete in the cycle of their transfer. A step element with the
// last flag starts the computation; the block then accepts nothing until its
// DIM results have been transferred.
// Each activation's run time is set by the bit-serial divider inside the
// shared exponential series unit. A step runs 2*DIM activations besides
// its MAC passes. After reset a clearing pass zeroes all BATCH*DIM hidden
// store entries before the first transfer is accepted. A stalled result
// simply holds.
//
module gated_recurrent_cell_forward_core
  import grcf_pkg::*;
#(
  parameter int DIM   = 16,
  parameter int BATCH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // row[3:0], col[7:4], value[23:8], z_value[39:24]
  input  logic [4:0]  in_tuser,   // action[2:0], sequence_req[4:3]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // index[3:0], hidden_out[19:4], gated_out[35:20], 0
  output logic [1:0]  out_tuser,  // out_sequence[1:0]
  output logic        out_tlast
);

  localparam int KW     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int WDEPTH = DIM * DIM;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int HDEPTH = BATCH * DIM;
  localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int ACC_W  = 32 + $clog2(2 * DIM + 2);

  localparam logic [6:0]             DIM_L    = 7'(DIM);
  localparam logic [4:0]             BATCH_L  = 5'(BATCH);
  localparam logic [KW-1:0]          K_LAST   = KW'(DIM - 1);
  localparam logic [HAW-1:0]         H_LAST   = HAW'(HDEPTH - 1);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2048);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(-32768);

  // Sequencer states.
  typedef enum logic [8:0] {
    S_CLR  = 9'b0_0000_0001,
    S_IDLE = 9'b0_0000_0010,
    S_HMAC = 9'b0_0000_0100,
    S_HACT = 9'b0_0000_1000,
    S_COPY = 9'b0_0001_0000,
    S_GMAC = 9'b0_0010_0000,
    S_GACT = 9'b0_0100_0000,
    S_GMUL = 9'b0_1000_0000,
    S_OUT  = 9'b1_0000_0000
  } state_t;

  // Which product the MAC pipeline works on.
  typedef enum logic [2:0] {
    SEL_NONE = 3'd0,
    SEL_BIAS = 3'd1,
    SEL_IN   = 3'd2,
    SEL_REC  = 3'd3,
    SEL_Z    = 3'd4,
    SEL_GATE = 3'd5,
    SEL_OUT  = 3'd6
  } sel_t;

  state_t state_r, state_nxt;

  // Input field decode.
  logic [2:0]  in_action;
  logic [1:0]  in_seq;
  logic [3:0]  in_row, in_col;
  logic [15:0] in_value, in_zval;

  assign in_action = in_tuser[2:0];
  assign in_seq    = in_tuser[4:3];
  assign in_row    = in_tdata[3:0];
  assign in_col    = in_tdata[7:4];
  assign in_value  = in_tdata[23:8];
  assign in_zval   = in_tdata[39:24];

  logic xfer_in, item_ok, col_ok, mat_ok;

  assign in_tready = (state_r == S_IDLE);
  assign xfer_in   = in_tvalid && in_tready;
  // Items for a lane at or beyond BATCH and unknown actions are dropped.
  assign item_ok   = xfer_in && (5'(in_seq) < BATCH_L) && (in_action <= ACTION_STEP);
  assign col_ok    = 7'(in_col) < DIM_L;
  assign mat_ok    = col_ok && (7'(in_row) < DIM_L);

  // Sequencer registers.
  logic [KW-1:0]  i_r, i_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [1:0]     lane_r, lane_nxt;
  sel_t           issue_r, issue_nxt;
  logic           st1_v_r, st1_v_nxt;
  sel_t           st1_sel_r, st1_sel_nxt;
  logic           xv_r, xv_nxt;
  logic           zv_r, zv_nxt;
  logic           st2_v_r, st2_v_nxt;
  logic signed [31:0]      prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [15:0]    gate_r, gate_nxt;
  logic [15:0]    h_keep_r, h_keep_nxt;
  logic [HAW-1:0] clr_r, clr_nxt;
  logic [DIM-1:0] x_valid_r, x_valid_nxt;
  logic [DIM-1:0] z_valid_r, z_valid_nxt;
  logic           cp_v_r, cp_v_nxt;
  logic           cp_end_r, cp_end_nxt;
  logic [KW-1:0]  cp_k_r, cp_k_nxt;

  logic           out_v_r, out_v_nxt;
  logic [1:0]     out_seq_r, out_seq_nxt;
  logic [3:0]     out_idx_r, out_idx_nxt;
  logic [15:0]    out_h_r, out_h_nxt;
  logic [15:0]    out_g_r, out_g_nxt;
  logic           out_last_r, out_last_nxt;

  // Memory ports.
  logic [WAW-1:0] w_wa, w_ra;
  logic [HAW-1:0] hs_wa, hs_ra;
  logic [KW-1:0]  nh_ra;
  logic           hs_we;
  logic [15:0]    hs_wd;
  logic           nh_we;
  logic [15:0]    w_in_rd, w_rec_rd, w_gate_rd, bias_rd, x_rd, z_rd, hs_rd, nh_rd;

  act_req_t act_req;
  act_rsp_t act_rsp;

  assign w_wa  = WAW'(in_row) * WAW'(DIM) + WAW'(in_col);
  assign w_ra  = WAW'(i_r) * WAW'(DIM) + WAW'(k_r);
  assign hs_ra = HAW'(lane_r) * HAW'(DIM) + HAW'(k_r);
  assign nh_ra = (issue_r == SEL_OUT) ? i_r : k_r;
  assign nh_we = (state_r == S_HACT) && act_rsp.done;

  // Hidden store write port: clearing pass, initial hidden loads, copy-back.
  always_comb begin
    hs_we = 1'b0;
    hs_wa = '0;
    hs_wd = '0;
    if (state_r == S_CLR) begin
      hs_we = 1'b1;
      hs_wa = clr_r;
    end else if (item_ok && (in_action == ACTION_HIDDEN) && col_ok) begin
      hs_we = 1'b1;
      hs_wa = HAW'(in_seq) * HAW'(DIM) + HAW'(in_col);
      hs_wd = in_value;
    end else if (cp_v_r) begin
      hs_we = 1'b1;
      hs_wa = HAW'(lane_r) * HAW'(DIM) + HAW'(cp_k_r);
      hs_wd = nh_rd;
    end
  end

  grcf_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_w_in (
    .clk(clk), .we(item_ok && (in_action == ACTION_W_IN) && mat_ok),
    .waddr(w_wa), .wdata(in_value), .raddr(w_ra), .rdata(w_in_rd)
  );

  grcf_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_w_rec (
    .clk(clk), .we(item_ok && (in_action == ACTION_W_REC) && mat_ok),
    .waddr(w_wa), .wdata(in_value), .raddr(w_ra), .rdata(w_rec_rd)
  );

  grcf_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_w_gate (
    .clk(clk), .we(item_ok && (in_action == ACTION_W_GATE) && mat_ok),
    .waddr(w_wa), .wdata(in_value), .raddr(w_ra), .rdata(w_gate_rd)
  );

  grcf_ram #(.WIDTH(16), .DEPTH(DIM)) u_bias (
    .clk(clk), .we(item_ok && (in_action == ACTION_BIAS) && col_ok),
    .waddr(KW'(in_col)), .wdata(in_value), .raddr(i_r), .rdata(bias_rd)
  );

  grcf_ram #(.WIDTH(16), .DEPTH(DIM)) u_x (
    .clk(clk), .we(item_ok && (in_action == ACTION_STEP) && col_ok),
    .waddr(KW'(in_col)), .wdata(in_value), .raddr(k_r), .rdata(x_rd)
  );

  grcf_ram #(.WIDTH(16), .DEPTH(DIM)) u_z (
    .clk(clk), .we(item_ok && (in_action == ACTION_STEP) && col_ok),
    .waddr(KW'(in_col)), .wdata(in_zval), .raddr(i_r), .rdata(z_rd)
  );

  grcf_ram #(.WIDTH(16), .DEPTH(HDEPTH)) u_hidden (
    .clk(clk), .we(hs_we), .waddr(hs_wa), .wdata(hs_wd), .raddr(hs_ra), .rdata(hs_rd)
  );

  grcf_ram #(.WIDTH(16), .DEPTH(DIM)) u_new_hidden (
    .clk(clk), .we(nh_we), .waddr(i_r), .wdata(act_rsp.result),
    .raddr(nh_ra), .rdata(nh_rd)
  );

  grcf_act u_act (
    .clk(clk), .rst_n(rst_n), .req(act_req), .rsp(act_rsp)
  );

  // MAC operand selection. Buffer entries not delivered in this step read as zero.
  logic signed [15:0] mul_a, mul_b;

  always_comb begin
    unique case (st1_sel_r)
      SEL_BIAS: begin
        mul_a = bias_rd;
        mul_b = ONE_Q12;
      end
      SEL_IN: begin
        mul_a = w_in_rd;
        mul_b = xv_r ? x_rd : 16'sd0;
      end
      SEL_REC: begin
        mul_a = w_rec_rd;
        mul_b = hs_rd;
      end
      SEL_Z: begin
        mul_a = zv_r ? z_rd : 16'sd0;
        mul_b = ONE_Q12;
      end
      SEL_GATE: begin
        mul_a = w_gate_rd;
        mul_b = nh_rd;
      end
      SEL_OUT: begin
        mul_a = nh_rd;
        mul_b = gate_r;
      end
      default: begin
        mul_a = 16'sd0;
        mul_b = 16'sd0;
      end
    endcase
  end

  // Round half up to Q4.12 and saturate.
  logic signed [ACC_W-1:0] rs_sh;
  logic [15:0]             sat_val;
  logic                    drained;

  assign rs_sh = (acc_r + RND_HALF) >>> 12;

  always_comb begin
    if (rs_sh > SAT_HI) begin
      sat_val = 16'h7FFF;
    end else if (rs_sh < SAT_LO) begin
      sat_val = 16'h8000;
    end else begin
      sat_val = rs_sh[15:0];
    end
  end

  assign drained = (issue_r == SEL_NONE) && !st1_v_r && !st2_v_r;

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    k_nxt        = k_r;
    lane_nxt     = lane_r;
    issue_nxt    = issue_r;
    gate_nxt     = gate_r;
    clr_nxt      = clr_r;
    x_valid_nxt  = x_valid_r;
    z_valid_nxt  = z_valid_r;
    cp_v_nxt     = 1'b0;
    cp_end_nxt   = cp_end_r;
    cp_k_nxt     = cp_k_r;
    out_v_nxt    = out_v_r;
    out_seq_nxt  = out_seq_r;
    out_idx_nxt  = out_idx_r;
    out_h_nxt    = out_h_r;
    out_g_nxt    = out_g_r;
    out_last_nxt = out_last_r;
    act_req.start = 1'b0;
    act_req.fn    = ACT_TANH;
    act_req.arg   = sat_val;

    // MAC pipeline: read issue, product register, accumulate.
    st1_v_nxt   = (issue_r != SEL_NONE);
    st1_sel_nxt = issue_r;
    xv_nxt      = x_valid_r[k_r];
    zv_nxt      = z_valid_r[i_r];
    st2_v_nxt   = st1_v_r;
    prod_nxt    = 32'(mul_a) * 32'(mul_b);
    h_keep_nxt  = (st1_v_r && (st1_sel_r == SEL_OUT)) ? nh_rd : h_keep_r;
    acc_nxt     = st2_v_r ? (acc_r + ACC_W'(prod_r)) : acc_r;

    unique case (issue_r)
      SEL_BIAS: issue_nxt = SEL_IN;
      SEL_IN: begin
        if (k_r == K_LAST) begin
          k_nxt     = '0;
          issue_nxt = SEL_REC;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      SEL_REC, SEL_GATE: begin
        if (k_r == K_LAST) begin
          k_nxt     = '0;
          issue_nxt = SEL_NONE;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      SEL_Z:   issue_nxt = SEL_GATE;
      SEL_OUT: issue_nxt = SEL_NONE;
      default: issue_nxt = SEL_NONE;
    endcase

    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + HAW'(1);
        if (clr_r == H_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_ok && (in_action == ACTION_STEP)) begin
          if (col_ok) begin
            x_valid_nxt[KW'(in_col)] = 1'b1;
            z_valid_nxt[KW'(in_col)] = 1'b1;
          end
          if (in_tlast) begin
            lane_nxt  = in_seq;
            i_nxt     = '0;
            k_nxt     = '0;
            acc_nxt   = '0;
            issue_nxt = SEL_BIAS;
            state_nxt = S_HMAC;
          end
        end
      end
      S_HMAC: begin
        if (drained) begin
          act_req.start = 1'b1;
          act_req.fn    = ACT_TANH;
          state_nxt     = S_HACT;
        end
      end
      S_HACT: begin
        if (act_rsp.done) begin
          if (i_r == K_LAST) begin
            k_nxt      = '0;
            cp_end_nxt = 1'b0;
            state_nxt  = S_COPY;
          end else begin
            i_nxt     = i_r + KW'(1);
            acc_nxt   = '0;
            issue_nxt = SEL_BIAS;
            state_nxt = S_HMAC;
          end
        end
      end
      S_COPY: begin
        // New hidden vector goes back to the lane's slot in the hidden store.
        if (!cp_end_r) begin
          cp_v_nxt = 1'b1;
          cp_k_nxt = k_r;
          if (k_r == K_LAST) begin
            cp_end_nxt = 1'b1;
            k_nxt      = '0;
          end else begin
            k_nxt = k_r + KW'(1);
          end
        end else if (!cp_v_r) begin
          cp_end_nxt = 1'b0;
          i_nxt      = '0;
          acc_nxt    = '0;
          issue_nxt  = SEL_Z;
          state_nxt  = S_GMAC;
        end
      end
      S_GMAC: begin
        if (drained) begin
          act_req.start = 1'b1;
          act_req.fn    = ACT_SIGMOID;
          state_nxt     = S_GACT;
        end
      end
      S_GACT: begin
        if (act_rsp.done) begin
          gate_nxt  = act_rsp.result;
          acc_nxt   = '0;
          issue_nxt = SEL_OUT;
          state_nxt = S_GMUL;
        end
      end
      S_GMUL: begin
        if (drained) begin
          out_v_nxt    = 1'b1;
          out_seq_nxt  = lane_r;
          out_idx_nxt  = 4'(i_r);
          out_h_nxt    = h_keep_r;
          out_g_nxt    = sat_val;
          out_last_nxt = (i_r == K_LAST);
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          out_v_nxt = 1'b0;
          if (out_last_r) begin
            x_valid_nxt = '0;
            z_valid_nxt = '0;
            state_nxt   = S_IDLE;
          end else begin
            i_nxt     = i_r + KW'(1);
            acc_nxt   = '0;
            issue_nxt = SEL_Z;
            state_nxt = S_GMAC;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      issue_r   <= SEL_NONE;
      st1_v_r   <= 1'b0;
      st2_v_r   <= 1'b0;
      cp_v_r    <= 1'b0;
      cp_end_r  <= 1'b0;
      out_v_r   <= 1'b0;
      x_valid_r <= '0;
      z_valid_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      issue_r   <= issue_nxt;
      st1_v_r   <= st1_v_nxt;
      st2_v_r   <= st2_v_nxt;
      cp_v_r    <= cp_v_nxt;
      cp_end_r  <= cp_end_nxt;
      out_v_r   <= out_v_nxt;
      x_valid_r <= x_valid_nxt;
      z_valid_r <= z_valid_nxt;
    end
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    lane_r     <= lane_nxt;
    st1_sel_r  <= st1_sel_nxt;
    xv_r       <= xv_nxt;
    zv_r       <= zv_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    gate_r     <= gate_nxt;
    h_keep_r   <= h_keep_nxt;
    cp_k_r     <= cp_k_nxt;
    out_seq_r  <= out_seq_nxt;
    out_idx_r  <= out_idx_nxt;
    out_h_r    <= out_h_nxt;
    out_g_r    <= out_g_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_g_r, out_h_r, out_idx_r};
  assign out_tuser  = out_seq_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== hw/rtl/grcf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grcf_checker
// Port-level checks of the gated recurrent cell forward core.
// ----------------------------------------------------------------------------
module grcf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic out_tlast
);

  // A pending result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // The block never takes input while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // After a result that is not the last, the next one is still being computed.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !in_tready && !out_tvalid)
    else $error("block idle in the middle of a result run");

  // The last result of a run returns the block to accepting input.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("block not ready after the last result");

endmodule

bind gated_recurrent_cell_forward_core grcf_checker u_grcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast)
);
`default_nettype wire
